### src/csn_pkg.sv
// Shared widths, codes and item types of the cylinder surface normal block.
package csn_pkg;

	localparam int CW      = 32;          // coordinate width
	localparam int AW      = 18;          // axis component width
	localparam int HW      = 31;          // height width
	localparam int EW      = 16;          // epsilon width
	localparam int NW      = 18;          // normal component width
	localparam int DW      = CW + 1;      // offset from base center
	localparam int PRW     = DW + AW;     // one product of the projection
	localparam int PW      = PRW + 2;     // projection, Q32.32
	localparam int TW      = 38;          // rounded projection, Q16.16
	localparam int TAW     = TW + AW;     // projection times axis
	localparam int RW      = 41;          // radial component
	localparam int LDW     = $clog2(RW);  // leading one position
	localparam int MW      = 30;          // normalized magnitude
	localparam int SQW     = 2 * MW;      // one square
	localparam int SW      = SQW + 2;     // sum of squares
	localparam int LW      = SW / 2;      // length, root of the sum
	localparam int QW      = 17;          // quotient bits
	localparam int NUMW    = MW + 17;     // dividend width
	localparam int FIFO_DEPTH_DEF = 4;

	localparam int PAW = 3;
	localparam logic [PAW-1:0] ADDR_EPSILON = 3'd0;
	localparam logic [EW-1:0]  EPS_RESET    = 16'd66;

	typedef enum logic [1:0] {
		FACE_SIDE   = 2'd0,
		FACE_BOTTOM = 2'd1,
		FACE_TOP    = 2'd2,
		FACE_DEGEN  = 2'd3
	} face_t;

	// Classified item handed from the front part to the back part.
	typedef struct packed {
		logic [2:0][DW-1:0] d;
		logic [2:0][AW-1:0] a;
		logic [TW-1:0]      t;
		face_t              face;
	} job_t;

	localparam int JOB_W = $bits(job_t);

endpackage

### src/csn_front.sv
// Front part: offset, projection onto the axis and cap classification.
module csn_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic signed [31:0]          hit_x,
	input  logic signed [31:0]          hit_y,
	input  logic signed [31:0]          hit_z,
	input  logic signed [31:0]          center_x,
	input  logic signed [31:0]          center_y,
	input  logic signed [31:0]          center_z,
	input  logic signed [17:0]          axis_x,
	input  logic signed [17:0]          axis_y,
	input  logic signed [17:0]          axis_z,
	input  logic [30:0]                 cyl_height,
	input  logic [csn_pkg::EW-1:0]      epsilon,
	output logic                        out_vld,
	output csn_pkg::job_t               job
);
	import csn_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [DW-1:0]  d_s1 [3], d_s2 [3], d_s3 [3];
	logic signed [AW-1:0]  a_s1 [3], a_s2 [3], a_s3 [3];
	logic [HW-1:0]         h_s1, h_s2, h_s3;
	logic signed [PRW-1:0] prod_s2 [3];
	logic signed [PW-1:0]  p_s3;
	job_t                  job_s4;

	logic [PW-1:0]        mag_p;
	logic signed [PW:0]   diff;
	logic [PW:0]          mag_d;
	logic signed [PW-1:0] p_rnd;
	logic [31:0]          eps_ext;
	face_t                face;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= DW'(hit_x) - DW'(center_x);
			d_s1[1] <= DW'(hit_y) - DW'(center_y);
			d_s1[2] <= DW'(hit_z) - DW'(center_z);
			a_s1[0] <= axis_x;
			a_s1[1] <= axis_y;
			a_s1[2] <= axis_z;
			h_s1    <= cyl_height;
			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= PRW'(d_s1[i]) * PRW'(a_s1[i]);
				d_s2[i]    <= d_s1[i];
				a_s2[i]    <= a_s1[i];
				d_s3[i]    <= d_s2[i];
				a_s3[i]    <= a_s2[i];
			end
			h_s2 <= h_s1;
			h_s3 <= h_s2;
			p_s3 <= PW'(prod_s2[0]) + PW'(prod_s2[1]) + PW'(prod_s2[2]);
			for (int i = 0; i < 3; i++) begin
				job_s4.d[i] <= d_s3[i];
				job_s4.a[i] <= a_s3[i];
			end
			job_s4.t    <= TW'(p_rnd >>> 16);
			job_s4.face <= face;
		end
	end

	// Both cap tests compare exact Q32.32 values against epsilon scaled up.
	always_comb begin
		eps_ext = {epsilon, 16'h0000};
		mag_p   = p_s3[PW-1] ? PW'(-p_s3) : PW'(p_s3);
		diff    = (PW+1)'(p_s3) - (PW+1)'({h_s3, 16'h0000});
		mag_d   = diff[PW] ? (PW+1)'(-diff) : (PW+1)'(diff);
		p_rnd   = p_s3 + PW'(32768);
		if (mag_p < PW'(eps_ext)) begin
			face = FACE_BOTTOM;
		end else if (mag_d < (PW+1)'(eps_ext)) begin
			face = FACE_TOP;
		end else begin
			face = FACE_SIDE;
		end
	end

	assign out_vld = vld_s4;
	assign job     = job_s4;

endmodule

### src/csn_fifo.sv
// Short queue of classified items between the front and back parts.
module csn_fifo #(
	parameter int DEPTH = csn_pkg::FIFO_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic          pop,
	input  csn_pkg::job_t din,
	output csn_pkg::job_t dout,
	output logic          full,
	output logic          empty
);
	import csn_pkg::*;

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	job_t            mem_q [DEPTH];
	logic [PTRW-1:0] wr_q, rd_q;
	logic [CNTW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTRW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTRW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	assign dout  = mem_q[rd_q];
	assign full  = (cnt_q == CNTW'(DEPTH));
	assign empty = (cnt_q == '0);

endmodule

### src/csn_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module csn_sqrt (
	input  logic                   clk,
	input  logic                   en,
	input  logic [csn_pkg::SW-1:0] x,
	output logic [csn_pkg::LW-1:0] root
);
	import csn_pkg::*;

	logic [SW-1:0] rem_q  [LW-1];
	logic [LW-1:0] root_q [LW];

	for (genvar j = 0; j < LW; j++) begin : g_st
		localparam int K = LW - 1 - j;
		logic [SW-1:0] rem_in;
		logic [LW-1:0] root_in;
		logic [SW:0]   trial;
		logic          take;

		if (j == 0) begin : g_first
			assign rem_in  = x;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_q[j-1];
			assign root_in = root_q[j-1];
		end

		// (root + 2^K)^2 - root^2 = root * 2^(K+1) + 2^(2K)
		assign trial = ((SW+1)'(root_in) << (K + 1)) | ((SW+1)'(1) << (2 * K));
		assign take  = ((SW+1)'(rem_in) >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				root_q[j] <= take ? (root_in | (LW'(1) << K)) : root_in;
			end
		end

		if (j < LW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[j] <= take ? (rem_in - SW'(trial)) : rem_in;
				end
			end
		end
	end

	assign root = root_q[LW-1];

endmodule

### src/csn_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module csn_div (
	input  logic                     clk,
	input  logic                     en,
	input  logic [csn_pkg::NUMW-1:0] num,
	input  logic [csn_pkg::LW-1:0]   den,
	output logic [csn_pkg::QW-1:0]   quo
);
	import csn_pkg::*;

	logic [NUMW-1:0] rem_q [QW-1];
	logic [LW-1:0]   den_q [QW-1];
	logic [QW-1:0]   quo_q [QW];

	for (genvar j = 0; j < QW; j++) begin : g_st
		localparam int K = QW - 1 - j;
		logic [NUMW-1:0] rem_in;
		logic [LW-1:0]   den_in;
		logic [QW-1:0]   quo_in;
		logic [NUMW:0]   sub;
		logic            take;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[j-1];
			assign den_in = den_q[j-1];
			assign quo_in = quo_q[j-1];
		end

		assign sub  = (NUMW+1)'(den_in) << K;
		assign take = ((NUMW+1)'(rem_in) >= sub);

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[j] <= take ? (quo_in | (QW'(1) << K)) : quo_in;
			end
		end

		if (j < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[j] <= take ? (rem_in - NUMW'(sub)) : rem_in;
					den_q[j] <= den_in;
				end
			end
		end
	end

	assign quo = quo_q[QW-1];

endmodule

### src/csn_back.sv
// Back part: radial vector, normalization, length and the final normal.
module csn_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_vld,
	input  csn_pkg::job_t            job,
	output logic                     out_vld,
	output logic signed [17:0]       normal_x,
	output logic signed [17:0]       normal_y,
	output logic signed [17:0]       normal_z,
	output logic [1:0]               face
);
	import csn_pkg::*;

	localparam int PRE_ST   = 7;
	localparam int BACK_LAT = PRE_ST + LW + 1 + QW + 1;

	typedef struct packed {
		logic [2:0][AW-1:0] a;
		face_t              face;
	} hdr_t;

	typedef struct packed {
		hdr_t               hdr;
		logic [2:0]         neg;
		logic               zero;
		logic [2:0][MW-1:0] u;
	} side_t;

	logic [BACK_LAT-1:0] vld_q;

	hdr_t hdr_s1, hdr_s2, hdr_s3, hdr_s4, hdr_s5, hdr_s6;
	logic signed [DW-1:0]  d_s1 [3];
	logic signed [TAW-1:0] ta_s1 [3];
	logic signed [TAW-1:0] rnd [3];
	logic signed [RW-1:0]  r_s2 [3];
	logic [RW-1:0]         u_s3 [3], u_s4 [3];
	logic [2:0]            neg_s3, neg_s4, neg_s5, neg_s6;
	logic [RW-1:0]         or_s3;
	logic [LDW-1:0]        lead;
	logic [LDW-1:0]        lead_s4;
	logic                  zero_s4, zero_s5, zero_s6;
	logic [MW-1:0]         un_s5 [3], un_s6 [3];
	logic [SQW-1:0]        sq_s6 [3];
	logic [SW-1:0]         sum_s7;
	side_t                 side_s7;
	side_t                 sq_line_q [LW];
	logic [LW-1:0]         len;
	logic [NUMW-1:0]       num_s8 [3];
	logic [LW-1:0]         den_s8;
	side_t                 side_s8;
	side_t                 dv_line_q [QW];
	logic [QW-1:0]         quo [3];
	side_t                 side_f;
	logic [NW-1:0]         nrm [3];
	logic [NW-1:0]         n_q [3];
	face_t                 face_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[BACK_LAT-2:0], in_vld};
		end
	end

	always_comb begin
		lead = '0;
		for (int b = 0; b < RW; b++) begin
			if (or_s3[b]) begin
				lead = LDW'(b);
			end
		end
		for (int i = 0; i < 3; i++) begin
			rnd[i] = ta_s1[i] + TAW'(32768);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hdr_s1.a    <= job.a;
			hdr_s1.face <= job.face;
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= $signed(job.d[i]);
				ta_s1[i] <= TAW'($signed(job.t)) * TAW'($signed(job.a[i]));
				r_s2[i]  <= RW'(d_s1[i]) - RW'(rnd[i] >>> 16);
				neg_s3[i] <= r_s2[i][RW-1];
				u_s3[i]  <= r_s2[i][RW-1] ? RW'(-r_s2[i]) : RW'(r_s2[i]);
				u_s4[i]  <= u_s3[i];
				// Bring the largest magnitude into [2^29, 2^30).
				if (lead_s4 >= LDW'(MW - 1)) begin
					un_s5[i] <= MW'(u_s4[i] >> (lead_s4 - LDW'(MW - 1)));
				end else begin
					un_s5[i] <= MW'(u_s4[i] << (LDW'(MW - 1) - lead_s4));
				end
				un_s6[i] <= un_s5[i];
				sq_s6[i] <= SQW'(un_s5[i]) * SQW'(un_s5[i]);
			end
			hdr_s2  <= hdr_s1;
			hdr_s3  <= hdr_s2;
			hdr_s4  <= hdr_s3;
			hdr_s5  <= hdr_s4;
			hdr_s6  <= hdr_s5;
			or_s3   <= RW'(r_s2[0][RW-1] ? -r_s2[0] : r_s2[0])
				| RW'(r_s2[1][RW-1] ? -r_s2[1] : r_s2[1])
				| RW'(r_s2[2][RW-1] ? -r_s2[2] : r_s2[2]);
			lead_s4 <= lead;
			zero_s4 <= (or_s3 == '0);
			neg_s4  <= neg_s3;
			neg_s5  <= neg_s4;
			neg_s6  <= neg_s5;
			zero_s5 <= zero_s4;
			zero_s6 <= zero_s5;
			sum_s7  <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
			side_s7.hdr  <= hdr_s6;
			side_s7.neg  <= neg_s6;
			side_s7.zero <= zero_s6;
			for (int i = 0; i < 3; i++) begin
				side_s7.u[i] <= un_s6[i];
			end
			sq_line_q[0] <= side_s7;
			for (int k = 1; k < LW; k++) begin
				sq_line_q[k] <= sq_line_q[k-1];
			end
			for (int i = 0; i < 3; i++) begin
				num_s8[i] <= NUMW'({sq_line_q[LW-1].u[i], 16'h0000}) + NUMW'(len >> 1);
			end
			den_s8  <= len;
			side_s8 <= sq_line_q[LW-1];
			dv_line_q[0] <= side_s8;
			for (int k = 1; k < QW; k++) begin
				dv_line_q[k] <= dv_line_q[k-1];
			end
			for (int i = 0; i < 3; i++) begin
				n_q[i] <= nrm[i];
			end
			face_q <= side_f.zero && (side_f.hdr.face == FACE_SIDE) ?
				FACE_DEGEN : side_f.hdr.face;
		end
	end

	csn_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.x    (sum_s7),
		.root (len)
	);

	for (genvar i = 0; i < 3; i++) begin : g_div
		csn_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s8[i]),
			.den (den_s8),
			.quo (quo[i])
		);
	end

	assign side_f = dv_line_q[QW-1];

	// Final selection between the cap normals, the degenerate case and the side.
	always_comb begin
		logic [QW-1:0] qc;
		logic [NW-1:0] qe;
		logic [AW-1:0] ai;
		for (int i = 0; i < 3; i++) begin
			qc = (quo[i] > QW'(65536)) ? QW'(65536) : quo[i];
			qe = NW'(qc);
			ai = side_f.hdr.a[i];
			case (side_f.hdr.face)
				FACE_BOTTOM: nrm[i] = (ai == {1'b1, {(AW-1){1'b0}}}) ?
					{1'b0, {(AW-1){1'b1}}} : NW'(-ai);
				FACE_TOP:    nrm[i] = NW'(ai);
				default:     nrm[i] = side_f.zero ? '0 : (side_f.neg[i] ? -qe : qe);
			endcase
		end
	end

	assign out_vld  = vld_q[BACK_LAT-1];
	assign normal_x = $signed(n_q[0]);
	assign normal_y = $signed(n_q[1]);
	assign normal_z = $signed(n_q[2]);
	assign face     = face_q;

endmodule

### src/cylinder_surface_normal.sv
// Top level of the cylinder surface normal block.
//
//   Channel   Handshake             Payload
//   in        in_valid / in_stall   hit_*, center_*, axis_*, cyl_height
//   out       out_valid / out_stall normal_x, normal_y, normal_z, face
//   config    APB write/read        epsilon at byte address 0
//
// The block takes one item per cycle while in_stall is low and returns one
// result per item, in order. An item passes through the front part, the queue
// and the back part in turn; the 31 stage square root and the 17 stage dividers
// make up most of the back part. Reset clears all valid bits and the queue, and
// returns epsilon to 66.
// A stall on the output holds the back part only; the front part keeps taking
// items until the queue between the two fills, and only then stalls the input.
module cylinder_surface_normal #(
	parameter int FIFO_DEPTH = csn_pkg::FIFO_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [csn_pkg::PAW-1:0]     paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [31:0]          hit_x,
	input  logic signed [31:0]          hit_y,
	input  logic signed [31:0]          hit_z,
	input  logic signed [31:0]          center_x,
	input  logic signed [31:0]          center_y,
	input  logic signed [31:0]          center_z,
	input  logic signed [17:0]          axis_x,
	input  logic signed [17:0]          axis_y,
	input  logic signed [17:0]          axis_z,
	input  logic [30:0]                 cyl_height,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [17:0]          normal_x,
	output logic signed [17:0]          normal_y,
	output logic signed [17:0]          normal_z,
	output logic [1:0]                  face
);
	import csn_pkg::*;

	logic [EW-1:0] eps_q;
	logic          front_en, back_en;
	logic          front_vld;
	job_t          front_job, q_job;
	logic          q_full, q_empty;
	logic          q_push, q_pop;

	// The register file holds a single register, the cap tolerance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (psel && penable && pwrite && (paddr == ADDR_EPSILON)) begin
			eps_q <= pwdata[EW-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_EPSILON) ? {{(32-EW){1'b0}}, eps_q} : '0;

	// The front part advances whenever the queue has room for its last stage.
	assign front_en = !q_full;
	assign in_stall = q_full;
	assign q_push   = front_en && front_vld;

	// The back part advances unless its output register holds a stalled item.
	assign back_en = !(out_valid && out_stall);
	assign q_pop   = back_en && !q_empty;

	csn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (front_en),
		.in_vld     (in_valid),
		.hit_x      (hit_x),
		.hit_y      (hit_y),
		.hit_z      (hit_z),
		.center_x   (center_x),
		.center_y   (center_y),
		.center_z   (center_z),
		.axis_x     (axis_x),
		.axis_y     (axis_y),
		.axis_z     (axis_z),
		.cyl_height (cyl_height),
		.epsilon    (eps_q),
		.out_vld    (front_vld),
		.job        (front_job)
	);

	csn_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.pop    (q_pop),
		.din    (front_job),
		.dout   (q_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	csn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (back_en),
		.in_vld   (!q_empty),
		.job      (q_job),
		.out_vld  (out_valid),
		.normal_x (normal_x),
		.normal_y (normal_y),
		.normal_z (normal_z),
		.face     (face)
	);

endmodule

### tb/sv/cylinder_surface_normal_test.sv
// Self-checking testbench for the cylinder surface normal block.
module cylinder_surface_normal_test;
	timeunit 1ns;
	timeprecision 1ps;
	import csn_pkg::*;

	localparam longint ONE       = 65536;
	localparam int     WATCHDOG  = 5000;
	localparam int     LATENCY   = 80;
	localparam int     LONG_HOLD = 400;

	// One input item of the block, field by field.
	typedef struct {
		logic signed [31:0] hx, hy, hz;
		logic signed [31:0] cx, cy, cz;
		logic signed [17:0] ax, ay, az;
		logic [30:0]        h;
	} hit_item_t;

	// One surface normal as the block reports it.
	typedef struct {
		logic signed [17:0] nx, ny, nz;
		face_t              face;
	} normal_t;

	// A directed item, optionally with its result written out by hand.
	typedef struct {
		hit_item_t item;
		bit        typed;
		normal_t   want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PAW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] hit_x = '0, hit_y = '0, hit_z = '0;
	logic signed [31:0] center_x = '0, center_y = '0, center_z = '0;
	logic signed [17:0] axis_x = '0, axis_y = '0, axis_z = '0;
	logic [30:0] cyl_height = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [17:0] normal_x, normal_y, normal_z;
	logic [1:0] face;

	cylinder_surface_normal uut (.*);

	always #1 clk = ~clk;

	// The testbench's own copy of the tolerance register.
	logic [EW-1:0] cap_tolerance = EPS_RESET;

	normal_t pending_normals[$];
	directed_row_t directed[$];
	int error_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Works out the normal and the face that the block must return for one item.
	function automatic normal_t surface_normal(input hit_item_t it);
		longint d[3], a[3], r[3];
		longint p, t, ht, tol, n;
		longint unsigned u[3], m, sum, len, q;
		logic [2:0][17:0] nv;
		normal_t res;
		d[0] = longint'(it.hx) - longint'(it.cx);
		d[1] = longint'(it.hy) - longint'(it.cy);
		d[2] = longint'(it.hz) - longint'(it.cz);
		a[0] = longint'(it.ax);
		a[1] = longint'(it.ay);
		a[2] = longint'(it.az);
		p = d[0] * a[0] + d[1] * a[1] + d[2] * a[2];
		tol = longint'(cap_tolerance) * ONE;
		ht = longint'(it.h) * ONE;
		m = 0;
		if ((p < 0 ? -p : p) < tol) begin
			// Bottom cap: negated axis, with the one overflow clamped.
			for (int i = 0; i < 3; i++) begin
				n = -a[i];
				if (n > 131071) n = 131071;
				nv[i] = n[17:0];
			end
			res.face = FACE_BOTTOM;
		end else if (((p - ht) < 0 ? ht - p : p - ht) < tol) begin
			for (int i = 0; i < 3; i++) nv[i] = a[i][17:0];
			res.face = FACE_TOP;
		end else begin
			t = (p + 32768) >>> 16;
			for (int i = 0; i < 3; i++) begin
				r[i] = d[i] - ((t * a[i] + 32768) >>> 16);
				u[i] = r[i] < 0 ? -r[i] : r[i];
				if (u[i] > m) m = u[i];
			end
			if (m == 0) begin
				nv = '0;
				res.face = FACE_DEGEN;
			end else begin
				while (m >= (64'd1 << 30)) begin
					m >>= 1;
					for (int i = 0; i < 3; i++) u[i] >>= 1;
				end
				while (m < (64'd1 << 29)) begin
					m <<= 1;
					for (int i = 0; i < 3; i++) u[i] <<= 1;
				end
				sum = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
				len = int_sqrt(sum);
				if (len == 0) len = 1;
				for (int i = 0; i < 3; i++) begin
					q = (u[i] * 65536 + len / 2) / len;
					if (q > 65536) q = 65536;
					n = r[i] < 0 ? -longint'(q) : longint'(q);
					nv[i] = n[17:0];
				end
				res.face = FACE_SIDE;
			end
		end
		res.nx = nv[0];
		res.ny = nv[1];
		res.nz = nv[2];
		return res;
	endfunction

	function automatic hit_item_t make_item(input longint hx, hy, hz, cx, cy, cz,
			input longint ax, ay, az, input longint h);
		hit_item_t it;
		it.hx = hx[31:0]; it.hy = hy[31:0]; it.hz = hz[31:0];
		it.cx = cx[31:0]; it.cy = cy[31:0]; it.cz = cz[31:0];
		it.ax = ax[17:0]; it.ay = ay[17:0]; it.az = az[17:0];
		it.h = h[30:0];
		return it;
	endfunction

	function automatic directed_row_t make_row(input hit_item_t it, input bit typed,
			input longint nx, ny, nz, input face_t f);
		directed_row_t row;
		row.item = it;
		row.typed = typed;
		row.want.nx = nx[17:0];
		row.want.ny = ny[17:0];
		row.want.nz = nz[17:0];
		row.want.face = f;
		return row;
	endfunction

	// Random item. Most are plausible hits on a cylinder with a unit axis: near a
	// cap, on the axis itself, or on the side. The rest are raw bit patterns.
	function automatic hit_item_t random_item();
		hit_item_t it;
		real vx, vy, vz, l;
		longint along, ctr;
		int kind;
		kind = $urandom_range(99);
		if (kind < 15) begin
			it = make_item(longint'($urandom), longint'($urandom), longint'($urandom),
				longint'($urandom), longint'($urandom), longint'($urandom),
				longint'($urandom), longint'($urandom), longint'($urandom),
				longint'($urandom));
			return it;
		end
		vx = real'($urandom_range(2000)) - 1000.0;
		vy = real'($urandom_range(2000)) - 1000.0;
		vz = real'($urandom_range(2000)) - 1000.0;
		if ($urandom_range(3) == 0) begin
			// Axis along one coordinate, either sign.
			vx = 0.0; vy = 0.0; vz = 0.0;
			case ($urandom_range(2))
				0: vx = $urandom_range(1) ? 1.0 : -1.0;
				1: vy = $urandom_range(1) ? 1.0 : -1.0;
				default: vz = $urandom_range(1) ? 1.0 : -1.0;
			endcase
		end
		l = $sqrt(vx * vx + vy * vy + vz * vz);
		if (l < 1.0) begin
			vz = 1.0;
			l = 1.0;
		end
		it.ax = 18'($rtoi(vx / l * 65536.0));
		it.ay = 18'($rtoi(vy / l * 65536.0));
		it.az = 18'($rtoi(vz / l * 65536.0));
		it.h = 31'($urandom_range(1, 40 * 65536));
		ctr = longint'($urandom_range(1 << 24)) - (1 << 23);
		it.cx = 32'(ctr);
		it.cy = 32'(ctr + longint'($urandom_range(1 << 20)) - (1 << 19));
		it.cz = 32'(-ctr);
		if (kind < 40) begin
			along = ($urandom_range(1) ? longint'(it.h) : 0)
				+ longint'($urandom_range(160)) - 80;
		end else begin
			along = longint'($urandom_range(32'(it.h)));
		end
		it.hx = 32'(longint'(it.cx) + (along * longint'(it.ax)) / ONE);
		it.hy = 32'(longint'(it.cy) + (along * longint'(it.ay)) / ONE);
		it.hz = 32'(longint'(it.cz) + (along * longint'(it.az)) / ONE);
		if (kind >= 50) begin
			it.hx = it.hx + $signed($urandom_range(1 << 22)) - (1 << 21);
			it.hy = it.hy + $signed($urandom_range(1 << 22)) - (1 << 21);
			it.hz = it.hz + $signed($urandom_range(1 << 22)) - (1 << 21);
		end
		return it;
	endfunction

	// Offers one item and waits until the block takes it. Valid stays high from
	// one item to the next unless a gap is drawn.
	task automatic send_item(input hit_item_t it, input bit typed, input normal_t want);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		hit_x <= it.hx; hit_y <= it.hy; hit_z <= it.hz;
		center_x <= it.cx; center_y <= it.cy; center_z <= it.cz;
		axis_x <= it.ax; axis_y <= it.ay; axis_z <= it.az;
		cyl_height <= it.h;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_normals.push_back(typed ? want : surface_normal(it));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_normals.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [EW-1:0] value);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_EPSILON; pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cap_tolerance = value;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_tolerance();
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
		paddr <= ADDR_EPSILON;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[EW-1:0] !== cap_tolerance) begin
			$error("epsilon expected %0d got %0d", cap_tolerance, prdata[EW-1:0]);
			error_count++;
		end
		psel <= 1'b0; penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random(input int count);
		normal_t none;
		none = '{default: '0, face: FACE_SIDE};
		repeat (count) send_item(random_item(), 1'b0, none);
	endtask

	// The receiver stalls at random, or holds off for a long stretch when asked.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Each result is checked against the oldest expected normal.
	always @(posedge clk) begin
		normal_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_normals.size() == 0) begin
				$error("result with no item waiting for it");
				error_count++;
			end else begin
				want = pending_normals.pop_front();
				if (normal_x !== want.nx) begin
					$error("normal_x expected %0d got %0d", want.nx, normal_x);
					error_count++;
				end
				if (normal_y !== want.ny) begin
					$error("normal_y expected %0d got %0d", want.ny, normal_y);
					error_count++;
				end
				if (normal_z !== want.nz) begin
					$error("normal_z expected %0d got %0d", want.nz, normal_z);
					error_count++;
				end
				if (face !== want.face) begin
					$error("face expected %0d got %0d", want.face, face);
					error_count++;
				end
			end
		end
	end

	// Watchdog: too long with neither channel nor the register port moving.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("cylinder_surface_normal_test: errors");
			$finish;
		end
	end

	initial begin
		logic [EW-1:0] tol_plan[5];
		int idle_plan[5];
		int stall_plan[5];

		// Bottom cap: the hit is the base center, so the normal is the negated axis.
		directed.push_back(make_row(make_item(0, 0, 0, 0, 0, 0, 0, 0, ONE, 10 * ONE),
			1'b1, 0, 0, -ONE, FACE_BOTTOM));
		// Top cap: the hit lies exactly one height up the axis.
		directed.push_back(make_row(make_item(ONE, 2 * ONE, 11 * ONE, ONE, 2 * ONE, ONE,
			0, 0, ONE, 10 * ONE), 1'b1, 0, 0, ONE, FACE_TOP));
		// Negating the most negative axis component clamps to the largest positive one.
		directed.push_back(make_row(make_item(0, 0, 0, 0, 0, 0, 0, 0, -131072, 10 * ONE),
			1'b1, 0, 0, 131071, FACE_BOTTOM));
		// A hit on the axis between the caps has no radial part at all.
		directed.push_back(make_row(make_item(0, 0, 5 * ONE, 0, 0, 0, 0, 0, ONE, 10 * ONE),
			1'b1, 0, 0, 0, FACE_DEGEN));
		// Plain side hits along x and along negative y.
		directed.push_back(make_row(make_item(3 * ONE, 0, 5 * ONE, 0, 0, 0, 0, 0, ONE,
			10 * ONE), 1'b1, ONE, 0, 0, FACE_SIDE));
		directed.push_back(make_row(make_item(0, -2 * ONE, 5 * ONE, 0, 0, 0, 0, 0, ONE,
			10 * ONE), 1'b1, 0, -ONE, 0, FACE_SIDE));
		// Just inside the bottom tolerance, then exactly on its edge.
		directed.push_back(make_row(make_item(0, 0, 65, 0, 0, 0, 0, 0, ONE, 10 * ONE),
			1'b1, 0, 0, -ONE, FACE_BOTTOM));
		directed.push_back(make_row(make_item(0, 0, 66, 0, 0, 0, 0, 0, ONE, 10 * ONE),
			1'b0, 0, 0, 0, FACE_SIDE));
		// Edges of the top tolerance.
		directed.push_back(make_row(make_item(0, 0, 10 * ONE - 65, 0, 0, 0, 0, 0, ONE,
			10 * ONE), 1'b0, 0, 0, 0, FACE_SIDE));
		directed.push_back(make_row(make_item(0, 0, 10 * ONE + 66, 0, 0, 0, 0, 0, ONE,
			10 * ONE), 1'b0, 0, 0, 0, FACE_SIDE));
		// Extremes of every field.
		directed.push_back(make_row(make_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 32'h80000000, ONE, -ONE, ONE, 31'h7FFFFFFF),
			1'b0, 0, 0, 0, FACE_SIDE));
		directed.push_back(make_row(make_item(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, -ONE, 131071, -131072, 0),
			1'b0, 0, 0, 0, FACE_SIDE));
		directed.push_back(make_row(make_item('1, '1, '1, '1, '1, '1, '1, '1, '1, '1),
			1'b0, 0, 0, 0, FACE_SIDE));
		directed.push_back(make_row(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b0, 0, 0, 0, FACE_SIDE));
		directed.push_back(make_row(make_item(32'h7FFFFFFF, 0, 32'h80000000, 0,
			32'h7FFFFFFF, 0, 131071, 131071, 131071, 31'h7FFFFFFF), 1'b0, 0, 0, 0,
			FACE_SIDE));
		// Axis of other than unit length.
		directed.push_back(make_row(make_item(4 * ONE, -ONE, 3 * ONE, ONE, ONE, 0,
			ONE / 2, ONE / 2, 0, 8 * ONE), 1'b0, 0, 0, 0, FACE_SIDE));
		directed.push_back(make_row(make_item(-7 * ONE, 9 * ONE, 2 * ONE, 0, 0, 0,
			3 * ONE / 2, -ONE / 4, ONE / 3, 8 * ONE), 1'b0, 0, 0, 0, FACE_SIDE));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_tolerance();

		// Directed walk under the reset tolerance, with no idling on either side.
		foreach (directed[i])
			send_item(directed[i].item, directed[i].typed, directed[i].want);
		drain();

		// Each phase sets a tolerance, among them both extremes, and an idling mode.
		tol_plan = '{16'd0, 16'hFFFF, 16'd1, EPS_RESET, 16'($urandom_range(65535))};
		idle_plan = '{0, 86, 0, 6, 0};
		stall_plan = '{0, 0, 86, 6, 0};
		for (int ph = 0; ph < 5; ph++) begin
			write_tolerance(tol_plan[ph]);
			read_tolerance();
			idle_pct = idle_plan[ph];
			stall_pct = stall_plan[ph];
			// The last phase opens with a long hold-off so the queue fills up and
			// the block has to stall its input.
			if (ph == 4) hold_request = LONG_HOLD;
			send_random(137);
			drain();
		end

		if (error_count == 0)
			$display("cylinder_surface_normal_test: clean");
		else
			$display("cylinder_surface_normal_test: errors");
		$finish;
	end

endmodule

### filelist.f
src/csn_pkg.sv
src/csn_front.sv
src/csn_fifo.sv
src/csn_sqrt.sv
src/csn_div.sv
src/csn_back.sv
src/cylinder_surface_normal.sv
tb/sv/cylinder_surface_normal_test.sv
